### rtl/topological_sort_engine_top_assert.svh
// Assertion macros used by the checker file of the topological sort engine.
`ifndef TOPOLOGICAL_SORT_ENGINE_TOP_ASSERT_SVH
`define TOPOLOGICAL_SORT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked also during reset.
`define TSE_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/tse_pkg.sv
// Package with command codes and controller/datapath interface types.
`default_nettype none

package tse_pkg;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_EDGE   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic load_begin;
        logic load_edge;
        logic clear_walk;
        logic phase;
        logic root_inc;
        logic push_root;
        logic step;
        logic emit_cycle;
        logic emit_init;
        logic emit_order;
    } t_ctrl_cmd;

    typedef struct packed {
        logic self_loop;
        logic root_done;
        logic root_eligible;
        logic top_cycle;
        logic walk_done;
        logic len_zero;
        logic emit_done;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/tse_ctrl.sv
// Controller state machine sequencing the load, walk and emit phases.
`default_nettype none

module tse_ctrl import tse_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic [1:0] i_cmd,
    input  t_dp_status      i_status,
    output t_ctrl_cmd       o_ctrl,
    output logic            busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_ctrl  = '0;
        o_ctrl.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        CMD_BEGIN: o_ctrl.load_begin = 1'b1;
                        CMD_EDGE:  o_ctrl.load_edge  = 1'b1;
                        CMD_FINISH: begin
                            if (i_status.self_loop) begin
                                o_ctrl.emit_cycle = 1'b1;
                            end else begin
                                o_ctrl.clear_walk = 1'b1;
                                n_phase = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_status.root_done) begin
                    if (!r_phase) begin
                        // Cycle check passed; start the ordering pass.
                        o_ctrl.clear_walk = 1'b1;
                        n_phase = 1'b1;
                    end else if (i_status.len_zero) begin
                        n_state = S_IDLE;
                    end else begin
                        o_ctrl.emit_init = 1'b1;
                        n_state = S_EMIT;
                    end
                end else if (i_status.root_eligible) begin
                    o_ctrl.push_root = 1'b1;
                    n_state = S_WALK;
                end else begin
                    o_ctrl.root_inc = 1'b1;
                end
            end
            S_WALK: begin
                if (i_status.top_cycle) begin
                    o_ctrl.emit_cycle = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_ctrl.step = 1'b1;
                    if (i_status.walk_done) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_EMIT: begin
                o_ctrl.emit_order = 1'b1;
                if (i_status.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### rtl/tse_datapath.sv
// Datapath: edge store, walk marks, walk stack, order buffer and result register.
`default_nettype none

module tse_datapath import tse_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [5:0] i_vertex_count,
    input  wire logic [5:0] i_from_vertex,
    input  wire logic [5:0] i_to_vertex,
    input  t_ctrl_cmd       i_ctrl,
    output t_dp_status      o_status,
    output logic            o_valid,
    output logic [5:0]      o_vertex,
    output logic            o_has_cycle,
    output logic            o_last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] r_adj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_incoming;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_onpath;
    logic                    r_self_loop;
    logic [CW-1:0]           r_count;
    logic [VW-1:0]           r_stack [MAX_VERTICES];
    logic [VW-1:0]           r_order [MAX_VERTICES];
    logic [CW-1:0]           r_sp;
    logic [CW-1:0]           r_len;
    logic [CW-1:0]           r_root;
    logic [VW-1:0]           r_emit;
    logic                    r_valid;
    logic [5:0]              r_vertex;
    logic                    r_cycle;
    logic                    r_last;

    logic [CW-1:0]           w_sp_m1;
    logic [VW-1:0]           w_top;
    logic [MAX_VERTICES-1:0] w_row;
    logic [MAX_VERTICES-1:0] w_fresh;
    logic [VW-1:0]           w_next;
    logic [VW-1:0]           w_root_idx;
    logic [6:0]              w_from7;
    logic [6:0]              w_to7;
    logic [6:0]              w_cnt7;
    logic                    w_edge_ok;
    logic [6:0]              w_from_m1;
    logic [6:0]              w_to_m1;
    logic [6:0]              w_out_sum;

    assign w_sp_m1    = r_sp - CW'(1);
    assign w_top      = r_stack[w_sp_m1[VW-1:0]];
    assign w_row      = r_adj[w_top];
    assign w_fresh    = w_row & ~r_visited;
    assign w_root_idx = r_root[VW-1:0];

    // Lowest unvisited neighbor.
    always_comb begin
        w_next = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (w_fresh[i]) begin
                w_next = VW'(i);
            end
        end
    end

    assign w_from7   = 7'(i_from_vertex);
    assign w_to7     = 7'(i_to_vertex);
    assign w_cnt7    = 7'(r_count);
    assign w_edge_ok = (w_from7 != 7'd0) && (w_from7 <= w_cnt7) &&
                       (w_to7 != 7'd0) && (w_to7 <= w_cnt7);
    assign w_from_m1 = w_from7 - 7'd1;
    assign w_to_m1   = w_to7 - 7'd1;

    assign o_status.self_loop     = r_self_loop;
    assign o_status.root_done     = (r_root >= r_count);
    assign o_status.root_eligible = !r_visited[w_root_idx] &&
                                    (!i_ctrl.phase || !r_incoming[w_root_idx]);
    assign o_status.top_cycle     = |(w_row & r_onpath);
    assign o_status.walk_done     = (w_fresh == '0) && (r_sp == CW'(1));
    assign o_status.len_zero      = (r_len == '0);
    assign o_status.emit_done     = (r_emit == '0);

    // Edge store, marks and walk control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_adj[i] <= '0;
            end
            r_incoming  <= '0;
            r_visited   <= '0;
            r_onpath    <= '0;
            r_self_loop <= 1'b0;
            r_count     <= '0;
            r_sp        <= '0;
            r_len       <= '0;
            r_root      <= '0;
            r_emit      <= '0;
        end else begin
            if (i_ctrl.load_begin) begin
                for (int i = 0; i < MAX_VERTICES; i++) begin
                    r_adj[i] <= '0;
                end
                r_incoming  <= '0;
                r_self_loop <= 1'b0;
                if (7'(i_vertex_count) > 7'(MAX_VERTICES)) begin
                    r_count <= MAX_C;
                end else begin
                    r_count <= CW'(i_vertex_count);
                end
            end
            if (i_ctrl.load_edge && w_edge_ok) begin
                if (w_from7 == w_to7) begin
                    r_self_loop <= 1'b1;
                end else begin
                    r_adj[w_from_m1[VW-1:0]][w_to_m1[VW-1:0]] <= 1'b1;
                    r_incoming[w_to_m1[VW-1:0]] <= 1'b1;
                end
            end
            if (i_ctrl.clear_walk) begin
                r_visited <= '0;
                r_onpath  <= '0;
                r_len     <= '0;
                r_root    <= '0;
                r_sp      <= '0;
            end
            if (i_ctrl.root_inc) begin
                r_root <= r_root + CW'(1);
            end
            if (i_ctrl.push_root) begin
                r_root <= r_root + CW'(1);
                r_sp   <= CW'(1);
                r_visited[w_root_idx] <= 1'b1;
                r_onpath[w_root_idx]  <= 1'b1;
            end
            if (i_ctrl.step) begin
                if (w_fresh != '0) begin
                    r_sp <= r_sp + CW'(1);
                    r_visited[w_next] <= 1'b1;
                    r_onpath[w_next]  <= 1'b1;
                end else begin
                    r_sp <= w_sp_m1;
                    r_onpath[w_top] <= 1'b0;
                    if (r_len < MAX_C) begin
                        r_len <= r_len + CW'(1);
                    end
                end
            end
            if (i_ctrl.emit_init) begin
                r_emit <= w_sp_m1[VW-1:0] & '0 | VW'(r_len - CW'(1));
            end
            if (i_ctrl.emit_order) begin
                r_emit <= r_emit - VW'(1);
            end
        end
    end

    // Walk stack and postorder buffer.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push_root) begin
            r_stack[0] <= w_root_idx;
        end
        if (i_ctrl.step) begin
            if (w_fresh != '0) begin
                r_stack[r_sp[VW-1:0]] <= w_next;
            end else if (r_len < MAX_C) begin
                r_order[r_len[VW-1:0]] <= w_top;
            end
        end
    end

    assign w_out_sum = 7'(r_order[r_emit]) + 7'd1;

    // Result register; each word is shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.emit_cycle || i_ctrl.emit_order;
        end
        if (i_ctrl.emit_cycle) begin
            r_vertex <= 6'd0;
            r_cycle  <= 1'b1;
            r_last   <= 1'b1;
        end else if (i_ctrl.emit_order) begin
            r_vertex <= w_out_sum[5:0];
            r_cycle  <= 1'b0;
            r_last   <= (r_emit == '0);
        end
    end

    assign o_valid     = r_valid;
    assign o_vertex    = r_vertex;
    assign o_has_cycle = r_cycle;
    assign o_last      = r_last;

endmodule

`default_nettype wire

### rtl/topological_sort_engine_top.sv
// Top level of the topological sort engine: controller plus datapath.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+-------------------------------------------
//   command   | start, busy             | i_cmd, i_vertex_count, i_from_vertex, i_to_vertex
//   result    | o_valid (strobe)        | o_vertex, o_has_cycle, o_last
//
// Begin and edge words are taken while idle and busy stays low.
// A finish word keeps busy high while the graph is walked: each root candidate is
// scanned, each non-root vertex is pushed and each vertex popped, and each pass is
// closed, for two passes (cycle check, then ordering), then each vertex of the
// order is emitted; a cycle found during a walk ends it with a cycle report.
// A graph with a self loop answers in the following cycle without raising busy.
// Reset is synchronous and clears the edge store and all control state.
// Results cannot be stalled; each is on the ports for exactly one cycle.
`default_nettype none

module topological_sort_engine_top import tse_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_cmd,
    input  wire logic [5:0] i_vertex_count,
    input  wire logic [5:0] i_from_vertex,
    input  wire logic [5:0] i_to_vertex,
    output logic            o_valid,
    output logic [5:0]      o_vertex,
    output logic            o_has_cycle,
    output logic            o_last
);

    t_ctrl_cmd  w_ctrl;
    t_dp_status w_status;

    tse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .busy     (busy)
    );

    tse_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (i_vertex_count),
        .i_from_vertex  (i_from_vertex),
        .i_to_vertex    (i_to_vertex),
        .i_ctrl         (w_ctrl),
        .o_status       (w_status),
        .o_valid        (o_valid),
        .o_vertex       (o_vertex),
        .o_has_cycle    (o_has_cycle),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

### rtl/tse_checker.sv
// Port-level checker for the topological sort engine, bound to the top level.
`default_nettype none
`include "topological_sort_engine_top_assert.svh"

module tse_checker import tse_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_cmd,
    input wire logic       o_valid,
    input wire logic [5:0] o_vertex,
    input wire logic       o_has_cycle,
    input wire logic       o_last
);

    // A cycle report is a single final word with vertex zero.
    `TSE_ASSERT_NOW(a_cycle_word, i_clk, i_rst_n, o_valid && o_has_cycle, o_last && (o_vertex == 6'd0))
    // An order word never names vertex zero.
    `TSE_ASSERT_NOW(a_order_nonzero, i_clk, i_rst_n, o_valid && !o_has_cycle, o_vertex != 6'd0)
    // Reset leaves the block idle and quiet.
    `TSE_ASSERT_NEXT(a_reset_idle, i_clk, !i_rst_n, !busy && !o_valid)
    // Loading words never occupy the engine.
    `TSE_ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n && start && !busy && (i_cmd == CMD_BEGIN || i_cmd == CMD_EDGE), !busy || !i_rst_n)

endmodule

bind topological_sort_engine_top tse_checker u_tse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .o_vertex    (o_vertex),
    .o_has_cycle (o_has_cycle),
    .o_last      (o_last)
);

`default_nettype wire
